FILE: design/binary_mask_dilate_erode_outline_core_defines.svh
// Assertion macros shared by the mask morphology block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BINARY_MASK_DILATE_ERODE_OUTLINE_CORE_DEFINES_SVH
`define BINARY_MASK_DILATE_ERODE_OUTLINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BMDEO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BMDEO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bmdeo_pkg.sv
// Package for the mask morphology block: widths, mode codes and beat types.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package bmdeo_pkg;

  // Row word and active segment geometry.
  localparam int ROW_W   = 64;
  localparam int SEG_W   = 64;
  localparam int SEG_LSB = ROW_W - SEG_W;
  localparam int COL_W   = 7;

  // Pixel lanes that work side by side on one row.
  localparam int LANE_W  = 8;
  localparam int N_LANES = ROW_W / LANE_W;

  // Result queue.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Mask of the pixels that belong to the segment.
  localparam logic [ROW_W-1:0] SEG_MASK = {ROW_W{1'b1}} << SEG_LSB;

  // Operation codes held in the mode register.
  typedef enum logic [1:0] {
    MODE_DILATE  = 2'd0,
    MODE_ERODE   = 2'd1,
    MODE_OUTLINE = 2'd2,
    MODE_PASS    = 2'd3
  } mode_t;

  // One input beat.
  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             left_halo;
    logic             right_halo;
    logic             first_row;
    logic             last_row;
    logic             at_left_edge;
    logic [COL_W-1:0] right_edge_col;
  } item_t;

  // One result beat.
  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic             last;
  } result_t;

  // Neighbourhood of the row being worked on.
  typedef struct packed {
    logic [ROW_W-1:0] center;
    logic [ROW_W-1:0] above;
    logic [ROW_W-1:0] below;
    logic             left_halo;
    logic             right_halo;
    logic             is_top;
    logic             is_bottom;
    logic             left_edge;
    logic [COL_W-1:0] right_col;
  } row_ctx_t;

  // Pixel slices handed to one lane.
  typedef struct packed {
    logic [LANE_W-1:0] c;
    logic [LANE_W-1:0] up;
    logic [LANE_W-1:0] dn;
    logic [LANE_W-1:0] lf;
    logic [LANE_W-1:0] rt;
    logic [LANE_W-1:0] border;
  } lane_in_t;

endpackage

FILE: design/binary_mask_dilate_erode_outline_core.sv
// A result beat enters the four-entry result queue when the input beat that completes it is taken.
// One row is taken per cycle while the queue has room; a strip's bottom row yields two result
// beats when a row above it is pending and one otherwise, and the queue hands them out in order.
// Input is taken whenever the queue has two free entries; with the output always ready it
// never holds more than two beats, so input stalls only while the result side holds back.
// Reset (synchronous, rst high) empties the queue, clears both row buffers and sets the mode
// to dilate, the left edge flag to zero and the right edge column to 64.
`timescale 1ns / 1ps
`include "binary_mask_dilate_erode_outline_core_defines.svh"

module binary_mask_dilate_erode_outline_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                mode_we,
  input  logic [1:0]          mode_wdata,
  input  logic                item_valid,
  output logic                item_ready,
  input  bmdeo_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output bmdeo_pkg::result_t  result
);

  bmdeo_pkg::mode_t                     mode;
  logic [bmdeo_pkg::ROW_W-1:0]          above_row;
  logic [bmdeo_pkg::ROW_W-1:0]          center_row;
  logic                                 center_left_halo;
  logic                                 center_right_halo;
  logic                                 center_is_top;
  logic                                 have_center;
  logic                                 strip_left_edge;
  logic [bmdeo_pkg::COL_W-1:0]          strip_right_col;

  logic                                 accept;
  logic                                 have_eff;
  logic [bmdeo_pkg::ROW_W-1:0]          above_next;
  logic                                 left_edge_next;
  logic [bmdeo_pkg::COL_W-1:0]          right_col_next;
  bmdeo_pkg::row_ctx_t                  ctx_pend;
  bmdeo_pkg::row_ctx_t                  ctx_bot;
  logic [bmdeo_pkg::ROW_W-1:0]          row_pend;
  logic [bmdeo_pkg::ROW_W-1:0]          row_bot;
  bmdeo_pkg::result_t                   res_pend;
  bmdeo_pkg::result_t                   res_bot;
  logic                                 room;

  assign item_ready = room;
  assign accept     = item_valid && item_ready;

  // A new strip drops any pending row and restarts with an empty row above.
  assign have_eff       = have_center && !item.first_row;
  assign above_next     = have_eff ? center_row
                        : (item.first_row ? '0 : above_row);
  assign left_edge_next = item.first_row ? item.at_left_edge : strip_left_edge;
  assign right_col_next = item.first_row ? item.right_edge_col : strip_right_col;

  // Pending centre row, now that the row below it has arrived.
  always_comb begin
    ctx_pend.center     = center_row;
    ctx_pend.above      = above_row;
    ctx_pend.below      = item.row_bits;
    ctx_pend.left_halo  = center_left_halo;
    ctx_pend.right_halo = center_right_halo;
    ctx_pend.is_top     = center_is_top;
    ctx_pend.is_bottom  = 1'b0;
    ctx_pend.left_edge  = strip_left_edge;
    ctx_pend.right_col  = strip_right_col;
  end

  // Incoming row as the strip's bottom row, with an empty row below.
  always_comb begin
    ctx_bot.center     = item.row_bits;
    ctx_bot.above      = above_next;
    ctx_bot.below      = '0;
    ctx_bot.left_halo  = item.left_halo;
    ctx_bot.right_halo = item.right_halo;
    ctx_bot.is_top     = item.first_row;
    ctx_bot.is_bottom  = 1'b1;
    ctx_bot.left_edge  = left_edge_next;
    ctx_bot.right_col  = right_col_next;
  end

  bmdeo_row_unit u_row_pend (
    .mode    (mode),
    .ctx     (ctx_pend),
    .row_out (row_pend)
  );

  bmdeo_row_unit u_row_bot (
    .mode    (mode),
    .ctx     (ctx_bot),
    .row_out (row_bot)
  );

  assign res_pend.out_row = row_pend;
  assign res_pend.last    = 1'b0;
  assign res_bot.out_row  = row_bot;
  assign res_bot.last     = 1'b1;

  bmdeo_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push_a       (accept && have_eff),
    .data_a       (res_pend),
    .push_b       (accept && item.last_row),
    .data_b       (res_bot),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= bmdeo_pkg::MODE_DILATE;
    end else if (mode_we) begin
      mode <= bmdeo_pkg::mode_t'(mode_wdata);
    end
  end

  // Row buffers and strip edge settings.
  always_ff @(posedge clk) begin
    if (rst) begin
      above_row         <= '0;
      center_row        <= '0;
      center_left_halo  <= 1'b0;
      center_right_halo <= 1'b0;
      center_is_top     <= 1'b0;
      have_center       <= 1'b0;
      strip_left_edge   <= 1'b0;
      strip_right_col   <= bmdeo_pkg::COL_W'(64);
    end else if (accept) begin
      strip_left_edge <= left_edge_next;
      strip_right_col <= right_col_next;
      if (item.last_row) begin
        above_row         <= '0;
        center_row        <= '0;
        center_left_halo  <= 1'b0;
        center_right_halo <= 1'b0;
        center_is_top     <= 1'b0;
        have_center       <= 1'b0;
      end else begin
        above_row         <= above_next;
        center_row        <= item.row_bits;
        center_left_halo  <= item.left_halo;
        center_right_halo <= item.right_halo;
        center_is_top     <= item.first_row;
        have_center       <= 1'b1;
      end
    end
  end

  `BMDEO_ASSERT_NEXT(a_flush_empties, accept && item.last_row,
    !have_center && above_row == '0, "strip flush left a row pending")
  `BMDEO_ASSERT_NEXT(a_top_marked, accept && item.first_row && !item.last_row,
    have_center && center_is_top, "top row not held as pending centre")
  `BMDEO_ASSERT_NEXT(a_mode_write, mode_we, mode == $past(mode_wdata),
    "mode register did not take the written value")

endmodule

FILE: design/bmdeo_lane.sv
// One pixel lane: applies the selected morphology operation to a slice of pixels.
// Depends on bmdeo_pkg.
`timescale 1ns / 1ps

module bmdeo_lane (
  input  bmdeo_pkg::mode_t              mode,
  input  bmdeo_pkg::lane_in_t           px,
  output logic [bmdeo_pkg::LANE_W-1:0]  res
);

  logic [bmdeo_pkg::LANE_W-1:0] nb;

  // Any of the four neighbours is set.
  assign nb = px.up | px.dn | px.lf | px.rt;

  // Operation select.
  always_comb begin
    case (mode)
      bmdeo_pkg::MODE_DILATE:  res = px.c | nb;
      bmdeo_pkg::MODE_ERODE:   res = px.c & px.up & px.dn & px.lf & px.rt;
      bmdeo_pkg::MODE_OUTLINE: res = (~px.c & nb) | (px.c & px.border);
      default:                 res = px.c;
    endcase
  end

endmodule

FILE: design/bmdeo_row_unit.sv
// Row unit: forms the neighbour words of one row, runs the pixel lanes and merges
// their slices into the result row. Depends on bmdeo_pkg and bmdeo_lane.
`timescale 1ns / 1ps

module bmdeo_row_unit (
  input  bmdeo_pkg::mode_t             mode,
  input  bmdeo_pkg::row_ctx_t          ctx,
  output logic [bmdeo_pkg::ROW_W-1:0]  row_out
);

  logic [bmdeo_pkg::ROW_W-1:0] c;
  logic [bmdeo_pkg::ROW_W-1:0] up;
  logic [bmdeo_pkg::ROW_W-1:0] dn;
  logic [bmdeo_pkg::ROW_W-1:0] lf;
  logic [bmdeo_pkg::ROW_W-1:0] rt;
  logic [bmdeo_pkg::ROW_W-1:0] border;
  logic [bmdeo_pkg::ROW_W-1:0] merged;

  // Neighbour words; pixels below the segment are ignored.
  assign c  = ctx.center & bmdeo_pkg::SEG_MASK;
  assign up = ctx.above & bmdeo_pkg::SEG_MASK;
  assign dn = ctx.below & bmdeo_pkg::SEG_MASK;
  assign lf = ((c >> 1) | {ctx.left_halo, {(bmdeo_pkg::ROW_W-1){1'b0}}})
              & bmdeo_pkg::SEG_MASK;
  assign rt = ((c << 1) | ({{(bmdeo_pkg::ROW_W-1){1'b0}}, ctx.right_halo}
              << bmdeo_pkg::SEG_LSB)) & bmdeo_pkg::SEG_MASK;

  // Image border pixels: the whole row at top or bottom, plus edge columns.
  always_comb begin
    for (int i = 0; i < bmdeo_pkg::ROW_W; i++) begin
      border[bmdeo_pkg::ROW_W-1-i] = ctx.is_top || ctx.is_bottom
          || (i == 0 && ctx.left_edge)
          || (i < bmdeo_pkg::SEG_W && int'(ctx.right_col) == i);
    end
  end

  // Parallel lanes, each on its own slice of the row.
  for (genvar g = 0; g < bmdeo_pkg::N_LANES; g++) begin : g_lane
    bmdeo_pkg::lane_in_t px;

    assign px.c      = c[g*bmdeo_pkg::LANE_W +: bmdeo_pkg::LANE_W];
    assign px.up     = up[g*bmdeo_pkg::LANE_W +: bmdeo_pkg::LANE_W];
    assign px.dn     = dn[g*bmdeo_pkg::LANE_W +: bmdeo_pkg::LANE_W];
    assign px.lf     = lf[g*bmdeo_pkg::LANE_W +: bmdeo_pkg::LANE_W];
    assign px.rt     = rt[g*bmdeo_pkg::LANE_W +: bmdeo_pkg::LANE_W];
    assign px.border = border[g*bmdeo_pkg::LANE_W +: bmdeo_pkg::LANE_W];

    bmdeo_lane u_lane (
      .mode (mode),
      .px   (px),
      .res  (merged[g*bmdeo_pkg::LANE_W +: bmdeo_pkg::LANE_W])
    );
  end

  // Merge the lane slices; bits below the segment read as zero.
  assign row_out = merged & bmdeo_pkg::SEG_MASK;

endmodule

FILE: design/bmdeo_out_queue.sv
// Result queue: takes up to two result beats per cycle and hands out one per cycle while result_ready is high.
// Depends on bmdeo_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "binary_mask_dilate_erode_outline_core_defines.svh"

module bmdeo_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_a,
  input  bmdeo_pkg::result_t  data_a,
  input  logic                push_b,
  input  bmdeo_pkg::result_t  data_b,
  output logic                room,
  output logic                result_valid,
  input  logic                result_ready,
  output bmdeo_pkg::result_t  result
);

  bmdeo_pkg::result_t                 entries [bmdeo_pkg::QUEUE_DEPTH];
  logic [bmdeo_pkg::PTR_W-1:0]        wr_ptr;
  logic [bmdeo_pkg::PTR_W-1:0]        rd_ptr;
  logic [bmdeo_pkg::CNT_W-1:0]        count;
  logic [bmdeo_pkg::CNT_W-1:0]        count_next;
  logic [bmdeo_pkg::PTR_W-1:0]        wr_ptr_b;
  logic                               pop;

  // Room for the two beats that one input can cause.
  assign room         = count <= bmdeo_pkg::CNT_W'(bmdeo_pkg::QUEUE_DEPTH - 2);
  assign result_valid = count != '0;
  assign result       = entries[rd_ptr];
  assign pop          = result_valid && result_ready;

  // The second beat lands behind the first when both are pushed.
  assign wr_ptr_b   = wr_ptr + bmdeo_pkg::PTR_W'(push_a);
  assign count_next = count + bmdeo_pkg::CNT_W'(push_a) + bmdeo_pkg::CNT_W'(push_b)
                      - bmdeo_pkg::CNT_W'(pop);

  // Storage.
  always_ff @(posedge clk) begin
    if (push_a) begin
      entries[wr_ptr] <= data_a;
    end
    if (push_b) begin
      entries[wr_ptr_b] <= data_b;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + bmdeo_pkg::PTR_W'(push_a) + bmdeo_pkg::PTR_W'(push_b);
      rd_ptr <= rd_ptr + bmdeo_pkg::PTR_W'(pop);
      count  <= count_next;
    end
  end

  `BMDEO_ASSERT_NOW(a_no_overflow, push_a || push_b, room, "result queue overflow")
  `BMDEO_ASSERT_NOW(a_level_bound, 1'b1,
    count <= bmdeo_pkg::CNT_W'(bmdeo_pkg::QUEUE_DEPTH), "queue level out of range")
  `BMDEO_ASSERT_NEXT(a_drain_step, pop && !push_a && !push_b,
    count == $past(count) - 1'b1, "queue level did not drop on a lone pop")

endmodule
